// ----- rtl/qlm_pkg.sv -----
package qlm_pkg;

  localparam int DataW = 32;
  localparam int PfW   = 48;
  localparam int AccW  = 50;
  localparam int RadW  = 52;
  localparam int RootW = 26;
  localparam int CapW  = 25;

  localparam logic signed [DataW-1:0] GainVel  = 32'sd219113;
  localparam logic signed [DataW-1:0] GainAng  = 32'sd375495;
  localparam logic signed [DataW-1:0] GainRate = 32'sd1877469;
  localparam logic signed [DataW-1:0] AltReset = 32'sd55181312;
  localparam logic signed [DataW-1:0] MotorSq  = 32'sd196000000;
  localparam logic [CapW-1:0]         SumCap   = 25'd16777216;

  localparam logic [2:0] RegHover  = 3'd0;
  localparam logic [2:0] RegThrust = 3'd1;
  localparam logic [2:0] RegArm    = 3'd2;
  localparam logic [2:0] RegTorque = 3'd3;
  localparam logic [2:0] RegVscale = 3'd4;
  localparam logic [2:0] RegMaxMot = 3'd5;

  // Negated mixer terms per motor: bit 2 roll arm, bit 1 pitch arm, bit 0 yaw torque.
  localparam logic [2:0] MixNeg [4] = '{3'b111, 3'b100, 3'b001, 3'b010};

  typedef struct packed {
    logic signed [DataW-1:0] altitude;
    logic signed [DataW-1:0] altitude_ref;
    logic signed [DataW-1:0] roll;
    logic signed [DataW-1:0] pitch;
    logic signed [DataW-1:0] yaw;
    logic signed [DataW-1:0] rate_x;
    logic signed [DataW-1:0] rate_y;
    logic signed [DataW-1:0] rate_z;
  } in_item_t;

  typedef struct packed {
    logic [15:0] motor_one;
    logic [15:0] motor_two;
    logic [15:0] motor_three;
    logic [15:0] motor_four;
  } out_item_t;

  function automatic logic signed [AccW-1:0] sext32(input logic signed [DataW-1:0] v);
    return {{(AccW-DataW){v[DataW-1]}}, v};
  endfunction

  function automatic logic signed [AccW-1:0] sext48(input logic signed [PfW-1:0] v);
    return {{(AccW-PfW){v[PfW-1]}}, v};
  endfunction

  function automatic logic signed [DataW-1:0] sat32(input logic signed [AccW-1:0] v);
    if (v[AccW-1:DataW-1] == {(AccW-DataW+1){v[AccW-1]}}) begin
      return v[DataW-1:0];
    end else if (v[AccW-1]) begin
      return 32'sh80000000;
    end else begin
      return 32'sh7fffffff;
    end
  endfunction

endpackage

// ----- rtl/qlm_mul.sv -----
module qlm_mul (
  input  logic                                  clk,
  input  logic signed [qlm_pkg::DataW-1:0]      a,
  input  logic signed [qlm_pkg::DataW-1:0]      b,
  output logic signed [2*qlm_pkg::DataW-1:0]    p
);

  always_ff @(posedge clk) begin
    p <= (2*qlm_pkg::DataW)'(a) * (2*qlm_pkg::DataW)'(b);
  end

endmodule

// ----- rtl/qlm_isqrt.sv -----
module qlm_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [qlm_pkg::RadW-1:0]    radicand,
  output logic                        done,
  output logic [qlm_pkg::RootW-1:0]   root
);

  localparam int RemW = qlm_pkg::RootW + 1;
  localparam int CntW = $clog2(qlm_pkg::RootW);
  localparam logic [CntW-1:0] LastStep = CntW'(qlm_pkg::RootW - 1);

  logic [qlm_pkg::RadW-1:0] rad;
  logic [RemW-1:0]          rem;
  logic [CntW-1:0]          cnt;
  logic                     run;
  logic [RemW+1:0]          rem_sh;
  logic [RemW+1:0]          trial;
  logic [RemW+1:0]          diff;
  logic                     ge;

  always_comb begin
    rem_sh = {rem, rad[qlm_pkg::RadW-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
    diff   = rem_sh - trial;
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run <= 1'b0;
    end else if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
      run  <= 1'b1;
    end else if (run) begin
      rad <= {rad[qlm_pkg::RadW-3:0], 2'b00};
      if (ge) begin
        rem  <= diff[RemW-1:0];
        root <= {root[qlm_pkg::RootW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[RemW-1:0];
        root <= {root[qlm_pkg::RootW-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
      if (cnt == LastStep) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/quadrotor_lqr_mixer.sv -----
// Mixer sums that are non-positive give a zero command; every positive sum needs a square root.
// One item is processed at a time; a new input transaction is taken only once the previous
// result has been loaded, which waits while a stalled result is held at the output.
// Rate is set by the shared 32x32 multiplier (twelve products plus one per positive mixer
// sum) and the 26-step square root, run once per positive motor sum.
// Synchronous active-high reset restores register defaults and the filter state.
module quadrotor_lqr_mixer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  qlm_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output qlm_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_SQRT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [3:0] OpVel   = 4'd0;
  localparam logic [3:0] OpRoll  = 4'd1;
  localparam logic [3:0] OpRx    = 4'd2;
  localparam logic [3:0] OpPitch = 4'd3;
  localparam logic [3:0] OpRy    = 4'd4;
  localparam logic [3:0] OpYaw   = 4'd5;
  localparam logic [3:0] OpRz    = 4'd6;
  localparam logic [3:0] OpThr   = 4'd7;
  localparam logic [3:0] OpArm2  = 4'd8;
  localparam logic [3:0] OpArm3  = 4'd9;
  localparam logic [3:0] OpTorq  = 4'd10;
  localparam logic [3:0] OpDiff  = 4'd11;
  localparam logic [3:0] OpMotor = 4'd12;

  localparam int DW = qlm_pkg::DataW;
  localparam int AW = qlm_pkg::AccW;
  localparam int PW = qlm_pkg::PfW;

  logic [2:0]            state;
  logic [3:0]            op;
  logic [1:0]            mi;
  qlm_pkg::in_item_t     item;
  logic signed [DW-1:0]  hover, thrust_c, arm_c, torque_c, vscale;
  logic [15:0]           motor_ceiling;
  logic signed [DW-1:0]  prev_alt, vert_vel;
  logic signed [DW-1:0]  u1, u2, u3, u4;
  logic signed [PW-1:0]  t, a2, a3, q;
  logic signed [AW-1:0]  acc;
  logic [qlm_pkg::CapW-1:0] cap;
  logic [15:0]           motor [4];

  logic signed [DW-1:0]   mul_a, mul_b;
  logic signed [2*DW-1:0] prod;
  logic signed [PW-1:0]   pf;
  logic signed [AW-1:0]   pfe;
  logic signed [DW-1:0]   diff;
  logic signed [AW-1:0]   sum;
  logic [2:0]             neg;
  logic                   sq_start;
  logic                   sq_done;
  logic [qlm_pkg::RootW-1:0] root;
  logic [qlm_pkg::RootW-9:0] mval;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    pf   = prod[2*DW-1:16];
    pfe  = qlm_pkg::sext48(pf);
    diff = qlm_pkg::sat32(qlm_pkg::sext32(item.altitude) - qlm_pkg::sext32(prev_alt));
    neg  = qlm_pkg::MixNeg[mi];
    sum  = qlm_pkg::sext48(t)
         + (neg[2] ? -qlm_pkg::sext48(a2) : qlm_pkg::sext48(a2))
         + (neg[1] ? -qlm_pkg::sext48(a3) : qlm_pkg::sext48(a3))
         + (neg[0] ? -qlm_pkg::sext48(q)  : qlm_pkg::sext48(q));
    mval = root[qlm_pkg::RootW-1:8];
    sq_start = (state == S_ACC) && (op == OpMotor);
  end

  always_comb begin
    case (op)
      OpVel:   begin mul_a = qlm_pkg::GainVel;  mul_b = vert_vel;          end
      OpRoll:  begin mul_a = qlm_pkg::GainAng;  mul_b = item.roll;         end
      OpRx:    begin mul_a = qlm_pkg::GainRate; mul_b = item.rate_x;       end
      OpPitch: begin mul_a = qlm_pkg::GainAng;  mul_b = item.pitch;        end
      OpRy:    begin mul_a = qlm_pkg::GainRate; mul_b = item.rate_y;       end
      OpYaw:   begin mul_a = qlm_pkg::GainAng;  mul_b = item.yaw;          end
      OpRz:    begin mul_a = qlm_pkg::GainRate; mul_b = item.rate_z;       end
      OpThr:   begin mul_a = thrust_c;          mul_b = u1;                end
      OpArm2:  begin mul_a = arm_c;             mul_b = u2;                end
      OpArm3:  begin mul_a = arm_c;             mul_b = u3;                end
      OpTorq:  begin mul_a = torque_c;          mul_b = u4;                end
      OpDiff:  begin mul_a = diff;              mul_b = vscale;            end
      OpMotor: begin mul_a = {7'b0, cap};       mul_b = qlm_pkg::MotorSq;  end
      default: begin mul_a = '0;                mul_b = '0;                end
    endcase
  end

  qlm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  qlm_isqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (prod[qlm_pkg::RadW-1:0]),
    .done     (sq_done),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hover         <= '0;
      thrust_c      <= '0;
      arm_c         <= '0;
      torque_c      <= '0;
      vscale        <= 32'sd65536;
      motor_ceiling <= 16'hffff;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        qlm_pkg::RegHover:  hover         <= cfg_data;
        qlm_pkg::RegThrust: thrust_c      <= cfg_data;
        qlm_pkg::RegArm:    arm_c         <= cfg_data;
        qlm_pkg::RegTorque: torque_c      <= cfg_data;
        qlm_pkg::RegVscale: vscale        <= cfg_data;
        qlm_pkg::RegMaxMot: motor_ceiling <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OpVel;
      mi        <= '0;
      out_valid <= 1'b0;
      prev_alt  <= qlm_pkg::AltReset;
      vert_vel  <= '0;
    end else begin
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            op    <= OpVel;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          op <= op + 4'd1;
          unique case (op)
            OpDiff:  state <= S_SUM;
            OpMotor: state <= S_SQRT;
            default: state <= S_MUL;
          endcase
          case (op)
            OpVel:   u1 <= qlm_pkg::sat32(qlm_pkg::sext32(hover)
                         - qlm_pkg::sext32(item.altitude)
                         + qlm_pkg::sext32(item.altitude_ref) - pfe);
            OpRoll:  acc <= -pfe;
            OpRx:    u2 <= qlm_pkg::sat32(acc - pfe);
            OpPitch: acc <= pfe;
            OpRy:    u3 <= qlm_pkg::sat32(acc - pfe);
            OpYaw:   acc <= -pfe;
            OpRz:    u4 <= qlm_pkg::sat32(acc - pfe);
            OpThr:   t  <= pf;
            OpArm2:  a2 <= pf;
            OpArm3:  a3 <= pf;
            OpTorq:  q  <= pf;
            OpDiff: begin
              vert_vel <= qlm_pkg::sat32(pfe);
              prev_alt <= item.altitude;
              mi       <= '0;
            end
            default: ;
          endcase
        end
        S_SUM: begin
          if (sum[AW-1] || (sum == '0)) begin
            motor[mi] <= '0;
            mi        <= mi + 2'd1;
            state     <= (mi == 2'd3) ? S_OUT : S_SUM;
          end else begin
            if (sum > AW'(qlm_pkg::SumCap)) begin
              cap <= qlm_pkg::SumCap;
            end else begin
              cap <= sum[qlm_pkg::CapW-1:0];
            end
            op    <= OpMotor;
            state <= S_MUL;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            if (mval > (qlm_pkg::RootW-8)'(motor_ceiling)) begin
              motor[mi] <= motor_ceiling;
            end else begin
              motor[mi] <= mval[15:0];
            end
            mi    <= mi + 2'd1;
            state <= (mi == 2'd3) ? S_OUT : S_SUM;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_data.motor_one   <= motor[0];
            out_data.motor_two   <= motor[1];
            out_data.motor_three <= motor[2];
            out_data.motor_four  <= motor[3];
            out_valid            <= 1'b1;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/qlm_checker.sv -----
module qlm_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input qlm_pkg::out_item_t  out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result changed or was dropped.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("Input taken again right after a transaction.");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("Reset did not clear the handshake state.");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("Result appeared without work in progress.");

endmodule

bind quadrotor_lqr_mixer qlm_checker u_qlm_checker (.*);

// ----- test/tb_quadrotor_lqr_mixer.sv -----
`timescale 1ns / 100ps

class mixer_scoreboard;
  logic signed [31:0] hover;
  logic signed [31:0] thrust_k;
  logic signed [31:0] arm_k;
  logic signed [31:0] torque_k;
  logic signed [31:0] vel_scale;
  logic [15:0] motor_max;
  logic signed [31:0] last_alt;
  logic signed [31:0] velocity;
  qlm_pkg::out_item_t pending[$];
  int errors;

  function new();
    hover = 0;
    thrust_k = 0;
    arm_k = 0;
    torque_k = 0;
    vel_scale = 32'sd65536;
    motor_max = 16'hffff;
    last_alt = qlm_pkg::AltReset;
    velocity = 0;
    errors = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      qlm_pkg::RegHover: hover = val;
      qlm_pkg::RegThrust: thrust_k = val;
      qlm_pkg::RegArm: arm_k = val;
      qlm_pkg::RegTorque: torque_k = val;
      qlm_pkg::RegVscale: vel_scale = val;
      qlm_pkg::RegMaxMot: motor_max = val[15:0];
      default: ;
    endcase
  endfunction

  function longint qprod(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  function longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function logic [15:0] motor_cmd(longint sum);
    longint unsigned rad, root, bitv;
    if (sum <= 0) return 16'd0;
    if (sum > 64'sd16777216) sum = 64'sd16777216;
    rad = longint'(sum) * 64'd196000000;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rad) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rad >= root + bitv) begin
        rad = rad - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    root = root >> 8;
    if (root > motor_max) root = motor_max;
    return root[15:0];
  endfunction

  function void note_input(qlm_pkg::in_item_t it);
    longint u1, u2, u3, u4, t, a2, a3, q;
    qlm_pkg::out_item_t r;
    u1 = clip32(longint'(hover) - it.altitude + it.altitude_ref
                - qprod(qlm_pkg::GainVel, velocity));
    u2 = clip32(-qprod(qlm_pkg::GainAng, it.roll) - qprod(qlm_pkg::GainRate, it.rate_x));
    u3 = clip32(qprod(qlm_pkg::GainAng, it.pitch) - qprod(qlm_pkg::GainRate, it.rate_y));
    u4 = clip32(-qprod(qlm_pkg::GainAng, it.yaw) - qprod(qlm_pkg::GainRate, it.rate_z));
    t = qprod(thrust_k, u1);
    a2 = qprod(arm_k, u2);
    a3 = qprod(arm_k, u3);
    q = qprod(torque_k, u4);
    r.motor_one = motor_cmd(t - a2 - a3 - q);
    r.motor_two = motor_cmd(t - a2 + a3 + q);
    r.motor_three = motor_cmd(t + a2 + a3 - q);
    r.motor_four = motor_cmd(t + a2 - a3 + q);
    pending.push_back(r);
    velocity = clip32(qprod(clip32(longint'(it.altitude) - last_alt), vel_scale));
    last_alt = it.altitude;
  endfunction

  function void check_result(qlm_pkg::out_item_t got);
    qlm_pkg::out_item_t exp_r;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (got.motor_one !== exp_r.motor_one) begin
      $display("%0t: motor_one expected %0d actual %0d", $time, exp_r.motor_one, got.motor_one);
      errors++;
    end
    if (got.motor_two !== exp_r.motor_two) begin
      $display("%0t: motor_two expected %0d actual %0d", $time, exp_r.motor_two, got.motor_two);
      errors++;
    end
    if (got.motor_three !== exp_r.motor_three) begin
      $display("%0t: motor_three expected %0d actual %0d", $time, exp_r.motor_three,
               got.motor_three);
      errors++;
    end
    if (got.motor_four !== exp_r.motor_four) begin
      $display("%0t: motor_four expected %0d actual %0d", $time, exp_r.motor_four,
               got.motor_four);
      errors++;
    end
  endfunction
endclass

module tb_quadrotor_lqr_mixer;

  localparam logic [2:0] RegSpareA = 3'd6;
  localparam logic [2:0] RegSpareB = 3'd7;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  qlm_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  qlm_pkg::out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  mixer_scoreboard board;
  int cycles = 0;
  bit calm;

  quadrotor_lqr_mixer DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("quadrotor_lqr_mixer regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check_result(out_data);
    end
  end

  // The receiver stalls in random bursts until the final quiet stretch.
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge clk);
    while (1) begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 18);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(qlm_pkg::in_item_t it);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(it);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return $urandom_range(0, 32'h0004ffff) - 32'h00028000;
    endcase
  endfunction

  function automatic qlm_pkg::in_item_t rand_item();
    qlm_pkg::in_item_t it;
    it.altitude = (($urandom_range(0, 7) == 0) ? rand_word()
                   : 32'sd55181312 + $signed($urandom_range(0, 32'h000fffff)) - 32'sd524288);
    it.altitude_ref = (($urandom_range(0, 7) == 0) ? rand_word()
                       : it.altitude + $signed($urandom_range(0, 32'h000fffff)) - 32'sd524288);
    it.roll = rand_word();
    it.pitch = rand_word();
    it.yaw = rand_word();
    it.rate_x = rand_word();
    it.rate_y = rand_word();
    it.rate_z = rand_word();
    return it;
  endfunction

  task automatic random_config();
    write_cfg(qlm_pkg::RegHover, ($urandom_range(0, 3) == 0) ? rand_word()
              : $urandom_range(0, 32'h00a00000));
    write_cfg(qlm_pkg::RegThrust, ($urandom_range(0, 3) == 0) ? rand_word()
              : $urandom_range(0, 32'h00030000));
    write_cfg(qlm_pkg::RegArm, ($urandom_range(0, 3) == 0) ? rand_word()
              : $urandom_range(0, 32'h00010000));
    write_cfg(qlm_pkg::RegTorque, ($urandom_range(0, 3) == 0) ? rand_word()
              : $urandom_range(0, 32'h00010000));
    write_cfg(qlm_pkg::RegVscale, ($urandom_range(0, 3) == 0) ? rand_word()
              : $urandom_range(0, 32'h00640000));
    write_cfg(qlm_pkg::RegMaxMot, $urandom_range(0, 65535));
  endtask

  initial begin
    qlm_pkg::in_item_t it;
    logic [31:0] words[4];
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    board = new();
    words = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset coefficients give zero sums, hence zero commands.
    it = '0;
    send_item(it);
    drain();
    write_cfg(RegSpareA, 32'h12345678);
    write_cfg(RegSpareB, 32'hffffffff);
    write_cfg(qlm_pkg::RegHover, 32'h00100000);
    write_cfg(qlm_pkg::RegThrust, 32'h00010000);
    write_cfg(qlm_pkg::RegArm, 32'h00008000);
    write_cfg(qlm_pkg::RegTorque, 32'h00004000);
    write_cfg(qlm_pkg::RegVscale, 32'h00640000);
    write_cfg(qlm_pkg::RegMaxMot, 32'h0000ffff);
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        it = {8{words[i]}};
        it.altitude_ref = words[j];
        it.roll = words[j];
        it.rate_y = words[(i + j) % 4];
        send_item(it);
      end
    end
    it = '0;
    it.altitude = 32'sd55181312;
    it.altitude_ref = 32'sd55181312 + 32'sd65536;
    send_item(it);
    drain();
    write_cfg(qlm_pkg::RegMaxMot, 32'h00000000);
    write_cfg(qlm_pkg::RegThrust, 32'h7fffffff);
    write_cfg(qlm_pkg::RegArm, 32'h80000000);
    write_cfg(qlm_pkg::RegTorque, 32'h7fffffff);
    write_cfg(qlm_pkg::RegHover, 32'h80000000);
    write_cfg(qlm_pkg::RegVscale, 32'h80000000);
    for (int i = 0; i < 4; i++) begin
      it = {8{words[i]}};
      send_item(it);
    end
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      random_config();
      for (int k = 0; k < 220; k++) begin
        send_item(rand_item());
      end
      drain();
    end
    calm = 1'b1;
    random_config();
    for (int k = 0; k < 200; k++) begin
      send_item(rand_item());
    end
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("quadrotor_lqr_mixer regression: pass");
    end else begin
      $display("quadrotor_lqr_mixer regression: fail");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/qlm_pkg.sv
rtl/qlm_mul.sv
rtl/qlm_isqrt.sv
rtl/quadrotor_lqr_mixer.sv
rtl/qlm_checker.sv
test/tb_quadrotor_lqr_mixer.sv
